FILE: rtl/core/frfm_pkg.sv
// Package for the FIFO with delete-by-value.
// Holds the request and status codes, field widths and the cell command struct.
// No dependencies.
package frfm_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Command broadcast from the controller to every cell in the chain.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic                    remove;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: rtl/core/frfm_req_if.sv
// Request channel of the FIFO with delete-by-value: valid/ready plus payload.
// Depends on frfm_pkg for field widths.
interface frfm_req_if
  import frfm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic signed [VAL_W-1:0]  operand_value;

  modport source (output valid, output req_type, output operand_value, input ready);
  modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

FILE: rtl/core/frfm_rsp_if.sv
// Response channel of the FIFO with delete-by-value: valid/ready plus payload.
// Depends on frfm_pkg for field widths.
interface frfm_rsp_if
  import frfm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  popped_value;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output popped_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input occupancy,
                  output ready);
endinterface

FILE: rtl/core/frfm_cell.sv
// One storage cell of the queue chain: holds one entry, compares it with the
// search value and takes its younger neighbor's entry when the gap closes.
// Depends on frfm_pkg.
module frfm_cell
  import frfm_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic signed [VAL_W-1:0]  next_entry_i,
  input  logic                     found_i,
  output logic                     found_o,
  output logic signed [VAL_W-1:0]  entry_o
);

  logic signed [VAL_W-1:0] entry_q, entry_d;
  logic                    occupied;
  logic                    hit;
  logic                    shift_en;

  assign occupied = CNT_W'(IDX) < count_i;
  assign hit      = cmd_i.remove && occupied && (entry_q == cmd_i.value);
  assign found_o  = found_i || hit;

  // Every cell from the first match onward moves one slot toward the front.
  assign shift_en = cmd_i.pop || (cmd_i.remove && found_o);

  always_comb begin
    entry_d = entry_q;
    if (shift_en) begin
      entry_d = next_entry_i;
    end else if (cmd_i.push && (count_i == CNT_W'(IDX))) begin
      entry_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/core/fifo_remove_first_match.sv
// FIFO of signed 32-bit values with push, pop and remove-first-match, built as
// a chain of DEPTH cells. Each accepted transaction yields one response in the
// next cycle, and a new request is taken every cycle while the response
// register is empty or being drained, so the sustained rate is one request per
// cycle. A remove compares all cells at once and the match ripples down the
// chain, which sets the critical path; the gap closes in the same cycle.
// Depends on frfm_pkg, frfm_req_if, frfm_rsp_if and frfm_cell.
module fifo_remove_first_match
  import frfm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frfm_req_if.sink    req_i,
  frfm_rsp_if.source  rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic signed [VAL_W-1:0] popped_q;
  logic [OCC_W-1:0]        occ_q;

  logic                    accept;
  logic                    is_full, is_empty;
  cell_cmd_t               cmd;
  status_e                 status_d;
  logic signed [VAL_W-1:0] popped_d;

  logic                    found [DEPTH+1];
  logic signed [VAL_W-1:0] entry [DEPTH+1];

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_full     = count_q == CNT_W'(DEPTH);
  assign is_empty    = count_q == '0;

  always_comb begin
    cmd        = '0;
    cmd.value  = req_i.operand_value;
    if (accept) begin
      case (req_i.req_type)
        REQ_PUSH:   cmd.push   = !is_full;
        REQ_POP:    cmd.pop    = !is_empty;
        REQ_REMOVE: cmd.remove = 1'b1;
        default:    ;
      endcase
    end
  end

  assign found[0]     = 1'b0;
  // The last cell has no younger neighbor; what it takes lies beyond the count.
  assign entry[DEPTH] = entry[DEPTH-1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    frfm_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .next_entry_i (entry[g+1]),
      .found_i      (found[g]),
      .found_o      (found[g+1]),
      .entry_o      (entry[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    popped_d = '0;
    case (req_i.req_type)
      REQ_PUSH: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = entry[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (found[DEPTH]) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.popped_value = popped_q;
  assign rsp_o.occupancy    = occ_q;

endmodule

FILE: rtl/core/frfm_checker.sv
// Port-level checker for the FIFO with delete-by-value, bound to the top level.
// Depends on frfm_pkg and on the top level's ports.
module frfm_checker
  import frfm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [STAT_W-1:0]       status_i,
  input logic signed [VAL_W-1:0] popped_value_i,
  input logic [OCC_W-1:0]        occupancy_i
);

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(popped_value_i) && $stable(occupancy_i))
    else $error("stalled response changed");

  // Every accepted transaction shows its response in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("response missing after accepted request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |-> occupancy_i == '0)
    else $error("empty status with nonzero occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FULL |-> occupancy_i == OCC_W'(DEPTH))
    else $error("full status with wrong occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> popped_value_i == '0)
    else $error("failed request returned a value");

endmodule

bind fifo_remove_first_match frfm_checker #(
  .DEPTH (DEPTH)
) u_frfm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .popped_value_i (rsp_o.popped_value),
  .occupancy_i    (rsp_o.occupancy)
);

FILE: dv/tb.sv
// Self-checking testbench for fifo_remove_first_match: directed rows, then random
// push/pop/remove traffic with idling on both sides, checked against a queue model.
// Depends on frfm_pkg, frfm_req_if, frfm_rsp_if and the block itself.
module tb;
  import frfm_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int          N_RANDOM       = 1950;
  localparam int          QUIET_ITEMS    = 250;
  localparam int          PAUSE_AT       = 1100;
  localparam int          HOLD_AT        = 500;
  localparam int          HOLD_CYCLES    = 90;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MODE_SPAN      = 48;

  localparam logic [TYPE_W-1:0]       REQ_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7fff_ffff;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] popped;
    logic [OCC_W-1:0]        occ;
  } fifo_resp_t;

  typedef struct packed {
    logic [TYPE_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    fifo_resp_t              resp;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  frfm_req_if req_if ();
  frfm_rsp_if rsp_if ();

  fifo_remove_first_match #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  logic signed [VAL_W-1:0] shadow_fifo_q[$];
  fifo_resp_t              pending_resp_q[$];
  req_row_t                directed_rows[$];
  int                      items_sent   = 0;
  int                      items_rcvd   = 0;
  int                      total_items  = 0;
  int                      fail_count   = 0;
  int                      idle_cycles  = 0;
  bit                      sender_done  = 1'b0;

  // Applies one request to the shadow queue and returns the response it implies.
  function automatic fifo_resp_t next_response(logic [TYPE_W-1:0] kind,
                                               logic signed [VAL_W-1:0] val);
    fifo_resp_t r;
    int         hit;
    r.status = ST_OK;
    r.popped = '0;
    hit      = -1;
    case (kind)
      REQ_PUSH: begin
        if (shadow_fifo_q.size() >= DEPTH) r.status = ST_FULL;
        else shadow_fifo_q.push_back(val);
      end
      REQ_POP: begin
        if (shadow_fifo_q.size() == 0) r.status = ST_EMPTY;
        else r.popped = shadow_fifo_q.pop_front();
      end
      REQ_REMOVE: begin
        for (int i = 0; i < shadow_fifo_q.size(); i++)
          if (hit < 0 && shadow_fifo_q[i] == val) hit = i;
        if (hit < 0) r.status = ST_NOT_FOUND;
        else shadow_fifo_q.delete(hit);
      end
      default: ;
    endcase
    r.occ = OCC_W'(shadow_fifo_q.size());
    return r;
  endfunction

  function automatic void add_row(logic [TYPE_W-1:0] kind, logic signed [VAL_W-1:0] val,
                                  logic typed, status_e st, logic signed [VAL_W-1:0] pv,
                                  logic [OCC_W-1:0] occ);
    req_row_t row;
    row.kind        = kind;
    row.value       = val;
    row.typed       = typed;
    row.resp.status = st;
    row.resp.popped = pv;
    row.resp.occ    = occ;
    directed_rows.push_back(row);
  endfunction

  initial begin : main
    logic signed [VAL_W-1:0] fill_val;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_PUSH;
    req_if.operand_value = '0;
    rsp_if.ready         = 1'b0;

    // Empty queue: pop, remove and the unused code all leave it untouched.
    add_row(REQ_POP,    32'sd0, 1'b1, ST_EMPTY,     '0, 5'd0);
    add_row(REQ_REMOVE, 32'sd0, 1'b1, ST_NOT_FOUND, '0, 5'd0);
    add_row(REQ_UNUSED, -32'sd1, 1'b1, ST_OK,       '0, 5'd0);
    // Duplicate values: the remove has to take the oldest copy.
    add_row(REQ_PUSH,   VAL_MIN, 1'b1, ST_OK, '0, 5'd1);
    add_row(REQ_PUSH,   VAL_MAX, 1'b1, ST_OK, '0, 5'd2);
    add_row(REQ_PUSH,   VAL_MIN, 1'b1, ST_OK, '0, 5'd3);
    add_row(REQ_REMOVE, VAL_MIN, 1'b0, ST_OK, '0, 5'd0);
    add_row(REQ_REMOVE, 32'sd7,  1'b0, ST_OK, '0, 5'd0);
    for (int k = 0; k < 14; k++) begin
      fill_val = k[0] ? (32'shAAAA_AAA0 + k) : (32'sh5555_5550 + k);
      add_row(REQ_PUSH, fill_val, 1'b1, ST_OK, '0, OCC_W'(3 + k));
    end
    add_row(REQ_PUSH,   32'sd1,         1'b1, ST_FULL, '0, OCC_W'(DEPTH));
    add_row(REQ_REMOVE, 32'shAAAA_AAAD, 1'b0, ST_OK, '0, 5'd0);
    add_row(REQ_UNUSED, VAL_MAX,        1'b0, ST_OK, '0, 5'd0);
    add_row(REQ_POP,    32'sd0,         1'b0, ST_OK, '0, 5'd0);
    total_items = directed_rows.size() + N_RANDOM;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sender_done && pending_resp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : sender
    req_row_t   cur;
    fifo_resp_t pred;
    int         gap;
    int         mode_cnt;
    bit         filling;
    bit         accepted;
    gap      = 0;
    mode_cnt = 0;
    filling  = 1'b1;
    cur      = '0;
    wait (rst_ni);
    while (items_sent < total_items) begin
      @(posedge clk_i);
      accepted = req_if.valid && req_if.ready;
      if (accepted) begin
        pred = next_response(cur.kind, cur.value);
        pending_resp_q.push_back(cur.typed ? cur.resp : pred);
        items_sent++;
      end
      if (!req_if.valid || accepted) begin
        if (items_sent == total_items) begin
          req_if.valid <= 1'b0;
        end else if (items_sent == PAUSE_AT && pending_resp_q.size() != 0) begin
          req_if.valid <= 1'b0;
        end else if (gap > 0) begin
          gap--;
          req_if.valid <= 1'b0;
        end else begin
          if (items_sent < directed_rows.size()) begin
            cur = directed_rows[items_sent];
          end else begin
            // Alternate between filling and draining so full and empty both recur.
            mode_cnt++;
            if (mode_cnt % MODE_SPAN == 0) filling = !filling;
            cur.typed = 1'b0;
            case ($urandom_range(0, 9))
              0:       cur.value = VAL_MIN;
              1:       cur.value = VAL_MAX;
              2, 3:    cur.value = int'($urandom_range(0, 6)) - 3;
              default: cur.value = $urandom;
            endcase
            case ($urandom_range(0, 99)) inside
              [0:2]:   cur.kind = REQ_UNUSED;
              [3:27]:  cur.kind = REQ_PUSH;
              [28:63]: cur.kind = filling ? REQ_PUSH : REQ_POP;
              [64:77]: cur.kind = REQ_POP;
              default: cur.kind = REQ_REMOVE;
            endcase
            if (cur.kind == REQ_REMOVE && shadow_fifo_q.size() > 0 &&
                $urandom_range(0, 3) != 0)
              cur.value = shadow_fifo_q[$urandom_range(0, shadow_fifo_q.size() - 1)];
          end
          req_if.valid         <= 1'b1;
          req_if.req_type      <= cur.kind;
          req_if.operand_value <= cur.value;
          if (items_sent < total_items - QUIET_ITEMS && $urandom_range(0, 11) == 0)
            gap = $urandom_range(1, 17);
        end
      end
    end
    sender_done = 1'b1;
  end

  initial begin : receiver
    fifo_resp_t want;
    int         stall;
    int         hold;
    bit         held_long;
    stall     = 0;
    hold      = 0;
    held_long = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        items_rcvd++;
        if (pending_resp_q.size() == 0) begin
          $error("response with nothing pending: status %0d, occupancy %0d",
                 rsp_if.status, rsp_if.occupancy);
          fail_count++;
        end else begin
          want = pending_resp_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            fail_count++;
          end
          if (rsp_if.popped_value !== want.popped) begin
            $error("popped_value: expected %0d, actual %0d", want.popped,
                   rsp_if.popped_value);
            fail_count++;
          end
          if (rsp_if.occupancy !== want.occ) begin
            $error("occupancy: expected %0d, actual %0d", want.occ, rsp_if.occupancy);
            fail_count++;
          end
        end
      end
      // One long hold-off lets the block back up and stall the request side.
      if (!held_long && items_rcvd >= HOLD_AT) begin
        held_long = 1'b1;
        hold      = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (items_sent < total_items - QUIET_ITEMS && $urandom_range(0, 11) == 0)
          stall = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
rtl/core/frfm_pkg.sv
rtl/core/frfm_req_if.sv
rtl/core/frfm_rsp_if.sv
rtl/core/frfm_cell.sv
rtl/core/fifo_remove_first_match.sv
rtl/core/frfm_checker.sv
dv/tb.sv
